FILE: design/julia_escape_time_pixel_defines.svh
// ----------------------------------------------------------------------------
// Julia escape-time pixel: assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and held off
// while the asynchronous reset is asserted.
// ----------------------------------------------------------------------------
`ifndef JULIA_ESCAPE_TIME_PIXEL_DEFINES_SVH
`define JULIA_ESCAPE_TIME_PIXEL_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JET_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define JET_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/jet_pkg.sv
// ----------------------------------------------------------------------------
// Julia escape-time pixel: package
// Types, constants and small functions shared by the pixel datapath modules.
// ----------------------------------------------------------------------------
package jet_pkg;

	// Image size used to map a pixel to its complex start value.
	localparam int WIDTH  = 800;
	localparam int HEIGHT = 800;

	// Field widths.
	localparam int COORD_W = 10;
	localparam int COUNT_W = 8;
	localparam int COLOR_W = 8;
	localparam int DATA_W  = 32;
	localparam int INDEX_W = 2;

	// Start value mapping: the magnitude of twice the offset from the center,
	// times seven, shifted up by START_SHIFT, is divided by the image size.
	localparam int SIZE_W      = 13;
	localparam int OFF_W       = SIZE_W + 1;
	localparam int MAG_W       = SIZE_W + 2;
	localparam int START_SHIFT = 25;
	// The product of the magnitude and 2^25 mod size stays below 2^RCP_N.
	localparam int RCP_N       = MAG_W + SIZE_W;
	localparam int RCP_M_W     = RCP_N + 2;
	// 2^25 divided by the smallest image size of 16 fits in QF_W bits.
	localparam int QF_W        = START_SHIFT - 3;
	localparam int QUO_W       = MAG_W + QF_W;

	// Escape bound of 2.0 in Q4.27.
	localparam logic signed [DATA_W-1:0] LIMIT_POS = 32'sd268435456;
	localparam logic signed [DATA_W-1:0] LIMIT_NEG = -32'sd268435456;

	// Saturation bounds for the widened sums.
	localparam logic signed [38:0] S39_MAX = 39'sd2147483647;
	localparam logic signed [38:0] S39_MIN = -39'sd2147483648;

	// Smallest iteration limit that runs at least one iteration.
	localparam logic [COUNT_W-1:0] MIN_ITER = 8'd2;

	// Configuration register indexes.
	localparam logic [INDEX_W-1:0] REG_C_REAL   = 2'd0;
	localparam logic [INDEX_W-1:0] REG_C_IMAG   = 2'd1;
	localparam logic [INDEX_W-1:0] REG_MAX_ITER = 2'd2;

	typedef struct packed {
		logic [COORD_W-1:0] pixel_x;
		logic [COORD_W-1:0] pixel_y;
	} pixel_t;

	typedef struct packed {
		logic [COORD_W-1:0] out_x;
		logic [COORD_W-1:0] out_y;
		logic [COUNT_W-1:0] escape_count;
		logic               drawn;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} result_t;

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} color_t;

	// Commands from the sequencer to the square-and-add unit.
	typedef struct packed {
		logic load;
		logic mul;
		logic add;
	} step_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_RE,
		ST_DIV_IM,
		ST_MUL,
		ST_ADD,
		ST_FINISH
	} state_t;

	// Clamp a widened sum to the signed 32-bit range.
	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [38:0] v);
		logic signed [DATA_W-1:0] r;
		if (v > S39_MAX) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < S39_MIN) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[DATA_W-1:0];
		end
		return r;
	endfunction

	// Band colour of an escape count; a count of zero is background black.
	function automatic color_t band_color(input logic [COUNT_W-1:0] esc);
		color_t c;
		if (esc == '0)          c = '{8'd0,   8'd0,   8'd0};
		else if (esc < 8'd15)   c = '{8'd0,   8'd0,   8'd0};
		else if (esc < 8'd20)   c = '{8'd255, 8'd255, 8'd0};
		else if (esc < 8'd25)   c = '{8'd100, 8'd255, 8'd0};
		else if (esc < 8'd30)   c = '{8'd0,   8'd255, 8'd0};
		else if (esc < 8'd40)   c = '{8'd0,   8'd255, 8'd100};
		else if (esc < 8'd50)   c = '{8'd0,   8'd255, 8'd255};
		else if (esc < 8'd60)   c = '{8'd0,   8'd100, 8'd255};
		else if (esc < 8'd70)   c = '{8'd0,   8'd0,   8'd255};
		else if (esc < 8'd80)   c = '{8'd100, 8'd0,   8'd255};
		else if (esc < 8'd90)   c = '{8'd255, 8'd0,   8'd255};
		else                    c = '{8'd255, 8'd255, 8'd255};
		return c;
	endfunction

endpackage

FILE: design/jet_div.sv
// ----------------------------------------------------------------------------
// Julia escape-time pixel: start value divider
// Two-stage divide by the constant image size that maps a scaled pixel
// offset to a signed, saturated Q4.27 start value.
// ----------------------------------------------------------------------------
module jet_div #(
	parameter int WIDTH  = jet_pkg::WIDTH,
	parameter int HEIGHT = jet_pkg::HEIGHT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [jet_pkg::MAG_W-1:0]     mag,
	input  logic                          neg,
	input  logic                          sel_y,
	output logic                          done,
	output logic signed [jet_pkg::DATA_W-1:0] quo
);
	import jet_pkg::*;

	// With 2^25 = q*size + r, mag*2^25/size = mag*q + mag*r/size. The second
	// numerator stays below 2^RCP_N, so its quotient is exact as a multiply by
	// m = ceil(2^s/size) and a shift by s = RCP_N + clog2(size).
	localparam longint unsigned SCALE = 64'd1 << START_SHIFT;
	localparam int SH_X = RCP_N + $clog2(WIDTH);
	localparam int SH_Y = RCP_N + $clog2(HEIGHT);

	localparam logic [QF_W-1:0]    Q_X = QF_W'(SCALE / 64'(WIDTH));
	localparam logic [QF_W-1:0]    Q_Y = QF_W'(SCALE / 64'(HEIGHT));
	localparam logic [SIZE_W-1:0]  R_X = SIZE_W'(SCALE % 64'(WIDTH));
	localparam logic [SIZE_W-1:0]  R_Y = SIZE_W'(SCALE % 64'(HEIGHT));
	localparam logic [RCP_M_W-1:0] M_X =
		RCP_M_W'(((64'd1 << SH_X) + 64'(WIDTH) - 64'd1) / 64'(WIDTH));
	localparam logic [RCP_M_W-1:0] M_Y =
		RCP_M_W'(((64'd1 << SH_Y) + 64'(HEIGHT) - 64'd1) / 64'(HEIGHT));

	localparam int PROD_W = RCP_N + RCP_M_W;

	localparam logic [QUO_W-1:0] QUO_MAX = QUO_W'(32'h7FFF_FFFF);
	localparam logic [QUO_W-1:0] QUO_MIN = QUO_W'(32'h8000_0000);

	logic                v_s1;
	logic                done_q;
	logic                sel_s1;
	logic                neg_s1;
	logic [RCP_N-1:0]    rmul_s1;
	logic [QUO_W-1:0]    qmul_s1;
	logic                neg_s2;
	logic [QUO_W-1:0]    quo_s2;

	logic [SIZE_W-1:0]   r_sel;
	logic [QF_W-1:0]     q_sel;
	logic [RCP_M_W-1:0]  m_sel;
	logic [PROD_W-1:0]   prod;
	logic [PROD_W-1:0]   frac;

	assign r_sel = sel_y ? R_Y : R_X;
	assign q_sel = sel_y ? Q_Y : Q_X;
	assign m_sel = sel_s1 ? M_Y : M_X;
	assign prod  = {{RCP_M_W{1'b0}}, rmul_s1} * {{RCP_N{1'b0}}, m_sel};
	assign frac  = sel_s1 ? (prod >> SH_Y) : (prod >> SH_X);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start;
			done_q <= v_s1;
		end
	end

	// The remainder quotient is below the magnitude, so it fits in MAG_W bits.
	always_ff @(posedge clk) begin
		if (start) begin
			rmul_s1 <= {{SIZE_W{1'b0}}, mag} * {{MAG_W{1'b0}}, r_sel};
			qmul_s1 <= {{QF_W{1'b0}}, mag} * {{MAG_W{1'b0}}, q_sel};
			sel_s1  <= sel_y;
			neg_s1  <= neg;
		end
		if (v_s1) begin
			quo_s2 <= qmul_s1 + {{(QUO_W-MAG_W){1'b0}}, frac[MAG_W-1:0]};
			neg_s2 <= neg_s1;
		end
	end

	// Apply the sign and clamp to the 32-bit range.
	always_comb begin
		if (!neg_s2) begin
			quo = (quo_s2 > QUO_MAX) ? 32'sh7FFF_FFFF : $signed(quo_s2[DATA_W-1:0]);
		end else begin
			quo = (quo_s2 > QUO_MIN) ? 32'sh8000_0000 : $signed(-quo_s2[DATA_W-1:0]);
		end
	end

	assign done = done_q;

endmodule

FILE: design/jet_step.sv
// ----------------------------------------------------------------------------
// Julia escape-time pixel: square-and-add unit
// Holds z and performs one step z = z*z + c: the three products are
// registered first, then come the saturated sums and the escape test.
// ----------------------------------------------------------------------------
module jet_step (
	input  logic                              clk,
	input  jet_pkg::step_ctl_t                ctl,
	input  logic signed [jet_pkg::DATA_W-1:0] load_re,
	input  logic signed [jet_pkg::DATA_W-1:0] load_im,
	input  logic signed [jet_pkg::DATA_W-1:0] c_real,
	input  logic signed [jet_pkg::DATA_W-1:0] c_imag,
	output logic                              escape
);
	import jet_pkg::*;

	logic signed [DATA_W-1:0] z_re_q;
	logic signed [DATA_W-1:0] z_im_q;
	logic signed [63:0]       prod_rr_s1;
	logic signed [63:0]       prod_ii_s1;
	logic signed [63:0]       prod_ri_s1;

	logic signed [63:0]       diff;
	logic signed [38:0]       sum_re;
	logic signed [38:0]       sum_im;
	logic signed [DATA_W-1:0] re_nx;
	logic signed [DATA_W-1:0] im_nx;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			z_re_q <= load_re;
			z_im_q <= load_im;
		end else if (ctl.add) begin
			z_re_q <= re_nx;
			z_im_q <= im_nx;
		end
		if (ctl.mul) begin
			prod_rr_s1 <= z_re_q * z_re_q;
			prod_ii_s1 <= z_im_q * z_im_q;
			prod_ri_s1 <= z_re_q * z_im_q;
		end
	end

	// The real part drops 27 fraction bits, the imaginary part 26 so that
	// the factor of two in 2*re*im comes for free. Both shifts floor.
	always_comb begin
		diff   = prod_rr_s1 - prod_ii_s1;
		sum_re = {{2{diff[63]}}, diff[63:27]} + {{7{c_real[DATA_W-1]}}, c_real};
		sum_im = {prod_ri_s1[63], prod_ri_s1[63:26]} + {{7{c_imag[DATA_W-1]}}, c_imag};
		re_nx  = sat32(sum_re);
		im_nx  = sat32(sum_im);
		escape = (re_nx > LIMIT_POS) || (re_nx < LIMIT_NEG) ||
		         (im_nx > LIMIT_POS) || (im_nx < LIMIT_NEG);
	end

endmodule

FILE: design/julia_escape_time_pixel.sv
// ----------------------------------------------------------------------------
// Julia escape-time pixel: top level
// A pixel runs through two start value divisions, one square-and-add step
// for each iteration run (0 to 254 of them) and the FINISH state, which
// waits for the output register. The input stalls meanwhile, so one pixel
// is in flight at a time.
// Reset clears the sequencer and handshakes; c_real and c_imag reset to 0,
// max_iterations to 255.
// ----------------------------------------------------------------------------
`include "julia_escape_time_pixel_defines.svh"

module julia_escape_time_pixel #(
	parameter int WIDTH  = jet_pkg::WIDTH,
	parameter int HEIGHT = jet_pkg::HEIGHT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Pixel coordinate channel.
	input  logic                          pix_valid,
	output logic                          pix_stall,
	input  jet_pkg::pixel_t               pix,
	// Result channel.
	output logic                          res_valid,
	input  logic                          res_stall,
	output jet_pkg::result_t              res,
	// Configuration write port.
	input  logic                          wr_en,
	input  logic [jet_pkg::INDEX_W-1:0]   wr_index,
	input  logic [jet_pkg::DATA_W-1:0]    wr_data
);
	import jet_pkg::*;

	// Configuration registers.
	logic signed [DATA_W-1:0] c_real_q;
	logic signed [DATA_W-1:0] c_imag_q;
	logic [COUNT_W-1:0]       max_iter_q;

	// Sequencer state and per-pixel registers.
	state_t             state_q;
	state_t             state_d;
	pixel_t             pix_q;
	logic signed [DATA_W-1:0] re_q;
	logic [COUNT_W-1:0] k_q;
	logic [COUNT_W-1:0] esc_q;

	// Output register.
	logic               res_valid_q;
	result_t            res_q;
	color_t             color;

	// Sequencer commands.
	logic               div_start;
	logic               div_sel_y;
	logic               re_ld;
	logic               k_ld;
	logic               k_inc;
	logic               esc_ld;
	logic [COUNT_W-1:0] esc_val;
	logic               res_load;
	step_ctl_t          step_ctl;

	// Divider operands and results.
	logic signed [OFF_W-1:0]  off;
	logic [OFF_W-1:0]         off_abs;
	logic [SIZE_W-1:0]        off_mag;
	logic [MAG_W:0]           mag7_wide;
	logic [MAG_W-1:0]         div_mag;
	logic                     div_neg;
	logic                     div_done;
	logic signed [DATA_W-1:0] div_quo;
	logic                     step_esc;

	// ------------------------------------------------------------------------
	// Configuration writes. The user must write only while the block is idle;
	// the block does not enforce it. Unknown indexes are dropped.
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_real_q   <= '0;
			c_imag_q   <= '0;
			max_iter_q <= 8'd255;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_C_REAL:   c_real_q   <= $signed(wr_data);
				REG_C_IMAG:   c_imag_q   <= $signed(wr_data);
				REG_MAX_ITER: max_iter_q <= wr_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Start value operands. The real part comes from the column taken straight
	// off the input port in the transfer cycle; the imaginary part comes from
	// the captured row once the real division is done. Twice the offset from
	// the center is formed so that the scale 3.5/size becomes 7*2^25/size.
	// ------------------------------------------------------------------------
	always_comb begin
		if (!div_sel_y) begin
			off = $signed({{(OFF_W-COORD_W-1){1'b0}}, pix.pixel_x, 1'b0})
			      - $signed(OFF_W'(WIDTH));
		end else begin
			off = $signed(OFF_W'(HEIGHT))
			      - $signed({{(OFF_W-COORD_W-1){1'b0}}, pix_q.pixel_y, 1'b0});
		end
		div_neg   = off[OFF_W-1];
		off_abs   = div_neg ? (-off) : off;
		off_mag   = off_abs[SIZE_W-1:0];
		// Times seven as a shift and a subtract.
		mag7_wide = {off_mag, 3'b000} - {3'b000, off_mag};
		div_mag   = mag7_wide[MAG_W-1:0];
	end

	jet_div #(
		.WIDTH  (WIDTH),
		.HEIGHT (HEIGHT)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.mag     (div_mag),
		.neg     (div_neg),
		.sel_y   (div_sel_y),
		.done    (div_done),
		.quo     (div_quo)
	);

	jet_step u_step (
		.clk     (clk),
		.ctl     (step_ctl),
		.load_re (re_q),
		.load_im (div_quo),
		.c_real  (c_real_q),
		.c_imag  (c_imag_q),
		.escape  (step_esc)
	);

	// ------------------------------------------------------------------------
	// Sequencer. A pixel is taken only in IDLE. The two start values are
	// divided one after the other, then the square-and-add unit alternates
	// between its multiply and add cycles until z leaves the square or the
	// iteration limit is reached. The finished result waits in FINISH until
	// the output register is free.
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		div_sel_y = 1'b0;
		re_ld     = 1'b0;
		k_ld      = 1'b0;
		k_inc     = 1'b0;
		esc_ld    = 1'b0;
		esc_val   = '0;
		res_load  = 1'b0;
		step_ctl  = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (pix_valid) begin
					div_start = 1'b1;
					state_d   = ST_DIV_RE;
				end
			end
			ST_DIV_RE: begin
				div_sel_y = 1'b1;
				if (div_done) begin
					re_ld     = 1'b1;
					div_start = 1'b1;
					state_d   = ST_DIV_IM;
				end
			end
			ST_DIV_IM: begin
				div_sel_y = 1'b1;
				if (div_done) begin
					step_ctl.load = 1'b1;
					k_ld          = 1'b1;
					esc_ld        = 1'b1;
					// A limit below two runs no iteration at all.
					state_d = (max_iter_q < MIN_ITER) ? ST_FINISH : ST_MUL;
				end
			end
			ST_MUL: begin
				step_ctl.mul = 1'b1;
				state_d      = ST_ADD;
			end
			ST_ADD: begin
				step_ctl.add = 1'b1;
				if (step_esc) begin
					esc_ld  = 1'b1;
					esc_val = k_q;
					state_d = ST_FINISH;
				end else if (({1'b0, k_q} + 9'd1) >= {1'b0, max_iter_q}) begin
					state_d = ST_FINISH;
				end else begin
					k_inc   = 1'b1;
					state_d = ST_MUL;
				end
			end
			ST_FINISH: begin
				if (!res_valid_q || !res_stall) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Per-pixel payload registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && pix_valid) begin
			pix_q <= pix;
		end
		if (re_ld) begin
			re_q <= div_quo;
		end
		if (k_ld) begin
			k_q <= 8'd1;
		end else if (k_inc) begin
			k_q <= k_q + 1'b1;
		end
		if (esc_ld) begin
			esc_q <= esc_val;
		end
	end

	// ------------------------------------------------------------------------
	// Output register. It holds a finished result until the transfer, and is
	// reloaded in the same cycle that its old contents leave.
	// ------------------------------------------------------------------------
	assign color = band_color(esc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= res_load || (res_valid_q && res_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q.out_x        <= pix_q.pixel_x;
			res_q.out_y        <= pix_q.pixel_y;
			res_q.escape_count <= esc_q;
			res_q.drawn        <= (esc_q != '0);
			res_q.red          <= color.red;
			res_q.green        <= color.green;
			res_q.blue         <= color.blue;
		end
	end

	assign pix_stall = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// ------------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------------
	`JET_ASSERT_NOW(a_iter_in_range, clk, arst_n, (state_q == ST_MUL),
		((k_q != '0) && (k_q < max_iter_q)), "iteration index outside the limit")
	`JET_ASSERT_NOW(a_no_overwrite, clk, arst_n, res_load,
		(!res_valid_q || !res_stall), "result register overwritten while stalled")
	`JET_ASSERT_NOW(a_drawn_match, clk, arst_n, res_valid_q,
		(res_q.drawn == (res_q.escape_count != '0)), "drawn flag disagrees with count")
	`JET_ASSERT_NOW(a_div_done_state, clk, arst_n, div_done,
		((state_q == ST_DIV_RE) || (state_q == ST_DIV_IM)), "divider done out of sequence")
	`JET_ASSERT_NEXT(a_escape_recorded, clk, arst_n, ((state_q == ST_ADD) && step_esc),
		((state_q == ST_FINISH) && (esc_q != '0)), "escape not recorded")

endmodule

FILE: tb/sv/julia_escape_time_pixel_tb.sv
// ----------------------------------------------------------------------------
// Julia escape-time pixel: testbench
// Sends pixel coordinates under several Julia constants and iteration limits.
// A scoreboard predicts each escape count and band color in Q4.27 fixed point
// and checks every result transfer, in order, against its prediction.
// ----------------------------------------------------------------------------
import jet_pkg::*;

class escape_scoreboard;

	// Shadow copy of the configuration registers.
	logic signed [DATA_W-1:0] c_re;
	logic signed [DATA_W-1:0] c_im;
	logic [COUNT_W-1:0]       iter_limit;

	result_t pending_results[$];
	int      errors;

	function new();
		c_re       = '0;
		c_im       = '0;
		iter_limit = 8'd255;
		errors     = 0;
	endfunction

	function void write_register(logic [INDEX_W-1:0] idx, logic [DATA_W-1:0] data);
		if (idx == REG_C_REAL) begin
			c_re = data;
		end else if (idx == REG_C_IMAG) begin
			c_im = data;
		end else if (idx == REG_MAX_ITER) begin
			iter_limit = data[COUNT_W-1:0];
		end
	endfunction

	function logic signed [DATA_W-1:0] clamp_q27(longint v);
		if (v > 64'sd2147483647) begin
			return 32'sh7FFF_FFFF;
		end else if (v < -64'sd2147483648) begin
			return 32'sh8000_0000;
		end
		return v[DATA_W-1:0];
	endfunction

	// Maps twice the offset from the center to Q4.27 with a scale of 3.5/size.
	// Signed division of longint rounds toward zero.
	function logic signed [DATA_W-1:0] start_coord(longint offset2, longint size);
		longint q;
		q = (offset2 * 7 * (64'sd1 << 25)) / size;
		return clamp_q27(q);
	endfunction

	function result_t predict_pixel(pixel_t p);
		result_t r;
		longint  re;
		longint  im;
		longint  nr;
		longint  ni;
		int      k;
		int      esc;
		re  = start_coord(2 * longint'(p.pixel_x) - WIDTH, WIDTH);
		im  = start_coord(HEIGHT - 2 * longint'(p.pixel_y), HEIGHT);
		esc = 0;
		for (k = 1; k < int'(iter_limit); k++) begin
			nr = ((re * re - im * im) >>> 27) + c_re;
			ni = ((re * im) >>> 26) + c_im;
			re = clamp_q27(nr);
			im = clamp_q27(ni);
			if (re > LIMIT_POS || re < LIMIT_NEG || im > LIMIT_POS || im < LIMIT_NEG) begin
				esc = k;
				break;
			end
		end
		r.out_x        = p.pixel_x;
		r.out_y        = p.pixel_y;
		r.escape_count = esc[COUNT_W-1:0];
		r.drawn        = (esc != 0);
		{r.red, r.green, r.blue} = 24'h000000;
		if (esc == 0 || esc < 15) {r.red, r.green, r.blue} = {8'd0,   8'd0,   8'd0};
		else if (esc < 20)        {r.red, r.green, r.blue} = {8'd255, 8'd255, 8'd0};
		else if (esc < 25)        {r.red, r.green, r.blue} = {8'd100, 8'd255, 8'd0};
		else if (esc < 30)        {r.red, r.green, r.blue} = {8'd0,   8'd255, 8'd0};
		else if (esc < 40)        {r.red, r.green, r.blue} = {8'd0,   8'd255, 8'd100};
		else if (esc < 50)        {r.red, r.green, r.blue} = {8'd0,   8'd255, 8'd255};
		else if (esc < 60)        {r.red, r.green, r.blue} = {8'd0,   8'd100, 8'd255};
		else if (esc < 70)        {r.red, r.green, r.blue} = {8'd0,   8'd0,   8'd255};
		else if (esc < 80)        {r.red, r.green, r.blue} = {8'd100, 8'd0,   8'd255};
		else if (esc < 90)        {r.red, r.green, r.blue} = {8'd255, 8'd0,   8'd255};
		else                      {r.red, r.green, r.blue} = {8'd255, 8'd255, 8'd255};
		return r;
	endfunction

	function void note_pixel(pixel_t p);
		pending_results.push_back(predict_pixel(p));
	endfunction

	function void compare_field(result_t e, string name, logic [31:0] exp_v,
			logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: pixel (%0d,%0d) %s: expected %0d, actual %0d",
				$time, e.out_x, e.out_y, name, exp_v, act_v);
			errors++;
		end
	endfunction

	function void check_result(result_t r);
		result_t e;
		if (pending_results.size() == 0) begin
			$display("%0t: result for pixel (%0d,%0d) with none expected",
				$time, r.out_x, r.out_y);
			errors++;
			return;
		end
		e = pending_results.pop_front();
		compare_field(e, "out_x",        e.out_x,        r.out_x);
		compare_field(e, "out_y",        e.out_y,        r.out_y);
		compare_field(e, "escape_count", e.escape_count, r.escape_count);
		compare_field(e, "drawn",        e.drawn,        r.drawn);
		compare_field(e, "red",          e.red,          r.red);
		compare_field(e, "green",        e.green,        r.green);
		compare_field(e, "blue",         e.blue,         r.blue);
	endfunction

endclass

module julia_escape_time_pixel_tb;

	// An index the block does not decode; writes to it must change nothing.
	localparam logic [INDEX_W-1:0] REG_UNUSED = 2'd3;

	// Covers the longest single pixel, which runs 254 iterations.
	localparam int TAIL_CYCLES = 600;

	// Slowest quiet stretch: a long sender gap, a full pixel of 254 iterations
	// and a long receiver stall, with ample margin on top.
	localparam int WATCHDOG_LIMIT = 8000;

	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS   = 153;

	logic    clk;
	logic    arst_n;
	logic    pix_valid;
	logic    pix_stall;
	pixel_t  pix;
	logic    res_valid;
	logic    res_stall;
	result_t res;
	logic    wr_en;
	logic [INDEX_W-1:0] wr_index;
	logic [DATA_W-1:0]  wr_data;

	// When set, neither side inserts gaps or stalls.
	bit calm;
	int stall_left;

	escape_scoreboard sb;

	julia_escape_time_pixel u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Idle length: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 20);
		return $urandom_range(50, 300);
	endfunction

	// A few well-known constants whose Julia sets are connected, so that
	// escape counts spread over all color bands.
	function automatic void pick_constant(int sel, output int cr, output int ci);
		case (sel)
			0: begin cr = -107374182; ci =  20937965;  end
			1: begin cr =  -53687091; ci =  80530637;  end
			2: begin cr =   38252052; ci =   1342177;  end
			3: begin cr =  -94188633; ci = -51566451;  end
			4: begin cr = -112071803; ci = -31151935;  end
			default: begin cr = 0;    ci = 107374182;  end
		endcase
	endfunction

	// Register writes happen only while the block is idle. The shadow copy
	// in the scoreboard is updated right away, before any further pixel.
	task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [DATA_W-1:0] data);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(negedge clk);
		wr_en    <= 1'b0;
		wr_data  <= $urandom;
		sb.write_register(idx, data);
	endtask

	task automatic configure(input int cr, input int ci, input logic [DATA_W-1:0] iter_word);
		write_reg(REG_C_REAL, cr);
		write_reg(REG_C_IMAG, ci);
		write_reg(REG_MAX_ITER, iter_word);
	endtask

	// One pixel transfer. The valid either stays high from the previous
	// transfer or is lowered for a gap first; it is never lowered and raised
	// in the same falling edge. The payload is noise while valid is low.
	task automatic send_pixel(input pixel_t p);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			pix_valid <= 1'b0;
			pix       <= pixel_t'($urandom);
			repeat (gap) @(negedge clk);
		end
		pix_valid <= 1'b1;
		pix       <= p;
		do @(posedge clk); while (pix_stall);
		sb.note_pixel(p);
	endtask

	task automatic send_xy(input int x, input int y);
		pixel_t p;
		p.pixel_x = COORD_W'(x);
		p.pixel_y = COORD_W'(y);
		send_pixel(p);
	endtask

	// Lower valid after the last transfer of a phase and wait until every
	// predicted result has come back. Each pixel gives exactly one result,
	// so an empty queue means the block is idle.
	task automatic drain();
		@(negedge clk);
		pix_valid <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
	endtask

	// Mostly pixels inside the image; some use the whole 10-bit range, which
	// maps to start values outside the usual window.
	function automatic pixel_t random_pixel();
		pixel_t p;
		if ($urandom_range(0, 9) == 0) begin
			p = pixel_t'($urandom);
		end else begin
			p.pixel_x = COORD_W'($urandom_range(0, WIDTH - 1));
			p.pixel_y = COORD_W'($urandom_range(0, HEIGHT - 1));
		end
		return p;
	endfunction

	// Result side: stall in random runs, sampled at the rising edge.
	initial begin
		res_stall  = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				res_stall <= 1'b1;
				stall_left--;
			end else begin
				res_stall <= 1'b0;
				if ($urandom_range(0, 7) == 0) stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) sb.check_result(res);
	end

	// Watchdog: any transfer or register write restarts the count.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((pix_valid && !pix_stall) || (res_valid && !res_stall) || wr_en) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : stimulus
		int ph;
		int i;
		int cr;
		int ci;
		logic [COUNT_W-1:0] iter;
		sb        = new();
		calm      = 1'b0;
		arst_n    = 1'b0;
		pix_valid = 1'b0;
		pix       = '0;
		wr_en     = 1'b0;
		wr_index  = '0;
		wr_data   = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset values: c = 0 and a limit of 255. The corners escape, the
		// center never does, and out-of-range indexes still get iterated.
		send_xy(0, 0);
		send_xy(799, 799);
		send_xy(0, 799);
		send_xy(799, 0);
		send_xy(400, 400);
		send_xy(1023, 1023);
		send_xy(800, 0);
		send_xy(599, 201);
		drain();

		// Constant at the extremes with a single iteration: the sums
		// saturate and every pixel escapes at the first step.
		configure(32'sh7FFF_FFFF, 32'sh8000_0000, 32'd2);
		send_xy(400, 400);
		send_xy(0, 1023);
		send_xy(1023, 512);
		drain();

		// Limits of zero and one run no iteration at all: nothing is drawn.
		configure(0, 0, 32'd0);
		send_xy(0, 0);
		send_xy(1023, 0);
		drain();
		write_reg(REG_MAX_ITER, 32'hFFFF_FF01);
		// A write to the undecoded index must leave the limit alone.
		write_reg(REG_UNUSED, 32'h0000_00FF);
		send_xy(0, 0);
		send_xy(512, 1023);
		drain();

		// A classic connected set, for counts across all bands.
		pick_constant(0, cr, ci);
		configure(cr, ci, 32'd255);
		send_xy(400, 400);
		send_xy(300, 420);
		send_xy(130, 400);
		send_xy(250, 380);
		send_xy(560, 360);
		send_xy(200, 400);
		drain();

		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			case ($urandom_range(0, 5))
				0: begin
					cr = $urandom;
					ci = $urandom;
				end
				1, 2, 3: begin
					pick_constant($urandom_range(0, 5), cr, ci);
					cr = cr + int'($urandom_range(0, 32'd1048576)) - 524288;
					ci = ci + int'($urandom_range(0, 32'd1048576)) - 524288;
				end
				4: begin
					cr = int'($urandom_range(0, 32'd536870912)) - 268435456;
					ci = int'($urandom_range(0, 32'd536870912)) - 268435456;
				end
				default: begin
					cr = ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
					ci = ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 0;
				end
			endcase
			case (ph % 5)
				0, 3:    iter = 8'd255;
				1:       iter = COUNT_W'($urandom_range(0, 255));
				2:       iter = COUNT_W'($urandom_range(2, 40));
				default: iter = COUNT_W'($urandom_range(100, 255));
			endcase
			// Upper bits of the limit word are junk the block must drop.
			configure(cr, ci, ($urandom & 32'hFFFF_FF00) | iter);
			if ($urandom_range(0, 2) == 0) write_reg(REG_UNUSED, $urandom);
			calm = ($urandom_range(0, 3) == 0);
			for (i = 0; i < PHASE_ITEMS; i++) send_pixel(random_pixel());
			drain();
		end

		// Nothing is outstanding; give a stray result time to show up.
		calm = 1'b1;
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending_results.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+design
design/jet_pkg.sv
design/jet_div.sv
design/jet_step.sv
design/julia_escape_time_pixel.sv
tb/sv/julia_escape_time_pixel_tb.sv
